FILE: rtl/core/oled_page_frame_packer_macros.svh
// Assertion macros shared by the frame packer modules.
`ifndef OLED_PAGE_FRAME_PACKER_MACROS_SVH
`define OLED_PAGE_FRAME_PACKER_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define OPFP_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OPFP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/oled_pfp_pkg.sv
// Constants and types of the OLED page frame packer.
package oled_pfp_pkg;

	localparam int COLUMNS    = 80;
	localparam int PAGES      = 8;
	localparam int IMAGE_ROWS = 60;
	localparam int HEADER_LEN = 3;
	localparam int DEPTH      = PAGES * COLUMNS;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W  = 6;
	localparam int COL_W  = 7;
	localparam int PAGE_W = 3;
	localparam int BYTE_W = 7;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_EMIT  = 1'b1;

	localparam logic [BYTE_W-1:0] POS_PAGE_CMD = BYTE_W'(0);
	localparam logic [BYTE_W-1:0] POS_COL_LOW  = BYTE_W'(1);
	localparam logic [BYTE_W-1:0] POS_COL_HIGH = BYTE_W'(2);
	localparam logic [BYTE_W-1:0] POS_LAST     = BYTE_W'(HEADER_LEN + COLUMNS - 1);

	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

	// Description of the next byte of the refresh stream.
	typedef struct packed {
		logic              is_data;
		logic [7:0]        cmd;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} emit_t;

endpackage

FILE: rtl/core/oled_pfp_if.sv
// Valid/ready channel interfaces for the request and result beats.
interface oled_pfp_req_if;
	import oled_pfp_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic             pixel;

	modport source (output valid, output func, output row, output col, output pixel,
		input ready);
	modport sink (input valid, input func, input row, input col, input pixel,
		output ready);
endinterface

interface oled_pfp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, output out_byte, output is_data, output last,
		input ready);
	modport sink (input valid, input out_byte, input is_data, input last,
		output ready);
endinterface

FILE: rtl/core/oled_pfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oled_pfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/oled_pfp_seq.sv
// Refresh cursor: tracks page and byte position and describes the next byte.
module oled_pfp_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	output oled_pfp_pkg::emit_t emit
);
	import oled_pfp_pkg::*;

	logic [PAGE_W-1:0] page_q;
	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			byte_q <= '0;
		end else if (advance) begin
			if (byte_q == POS_LAST) begin
				byte_q <= '0;
				page_q <= (page_q == PAGE_LAST) ? '0 : page_q + 1'b1;
			end else begin
				byte_q <= byte_q + 1'b1;
			end
		end
	end

	always_comb begin
		emit.addr    = ADDR_W'(page_q) * ADDR_W'(COLUMNS)
			+ ADDR_W'(byte_q - BYTE_W'(HEADER_LEN));
		emit.is_data = 1'b0;
		emit.last    = 1'b0;
		case (byte_q)
			POS_PAGE_CMD: emit.cmd = CMD_PAGE_BASE + 8'(page_q);
			POS_COL_LOW:  emit.cmd = CMD_COL_LOW;
			POS_COL_HIGH: emit.cmd = CMD_COL_HIGH;
			default: begin
				emit.cmd     = CMD_COL_LOW;
				emit.is_data = 1'b1;
				emit.last    = (byte_q == POS_LAST) && (page_q == PAGE_LAST);
			end
		endcase
	end
endmodule

FILE: rtl/core/oled_page_frame_packer.sv
// Top level of the OLED page frame packer: frame store read-modify-write and result stage.
//
// The block keeps an 80 by 8 page-mode frame store in one synchronous RAM. A pixel beat ORs
// its bit into byte [row/8][col] at bit row%8; an emit beat returns the next byte of the
// panel refresh (page command, two column commands, then 80 data bytes per page, data bytes
// cleared as they leave). Every beat has two steps: the request is accepted and the RAM
// read issued in the first, and the read data is modified and written back in the second,
// which the registered read data of the frame store makes necessary. While a beat is in
// its second step no new request is accepted, which keeps read and write of the same
// byte from overlapping. After reset the block runs a clearing pass, one frame store byte
// per cycle, during which req.ready stays low. Results sit in an output
// register. While it holds a result that the receiver has not yet taken, no request of
// either kind is accepted, so a stalled receiver holds off pixel beats as well; a request
// can still be taken in the cycle in which the waiting result leaves.
module oled_page_frame_packer (
	input  logic           clk,
	input  logic           arst_n,
	oled_pfp_req_if.sink   req,
	oled_pfp_rsp_if.source rsp
);
	import oled_pfp_pkg::*;

	// Clearing pass state.
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Modify and write-back stage.
	logic              busy_s1;
	logic              func_s1;
	logic              pix_ok_s1;
	logic [7:0]        mask_s1;
	logic [ADDR_W-1:0] addr_s1;
	emit_t             emit_s1;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_data_q;
	logic       last_q;

	emit_t             emit;
	logic              accept;
	logic              pix_ok;
	logic [ADDR_W-1:0] pix_addr;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;

	// A request is taken only when the RAM stage is free and the output register will be
	// empty by the time this beat reaches it.
	assign req.ready = !clr_busy_q && !busy_s1 && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Pixels outside the image or the frame store are dropped.
	assign pix_ok = ({1'b0, req.row} < (ROW_W + 1)'(IMAGE_ROWS))
		&& ({1'b0, req.col} < (COL_W + 1)'(COLUMNS))
		&& ({1'b0, req.row[ROW_W-1:3]} < (PAGE_W + 1)'(PAGES));
	assign pix_addr = ADDR_W'(req.row[ROW_W-1:3]) * ADDR_W'(COLUMNS) + ADDR_W'(req.col);
	assign raddr    = (req.func == FUNC_EMIT) ? emit.addr : pix_addr;

	oled_pfp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept && (req.func == FUNC_EMIT)),
		.emit   (emit)
	);

	oled_pfp_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Write port: the clearing pass owns it after reset; afterwards a pixel sets its bit and
	// a data byte that has been read out is written back as zero.
	always_comb begin
		if (clr_busy_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (func_s1 == FUNC_PIXEL) begin
			we    = busy_s1 && pix_ok_s1;
			waddr = addr_s1;
			wdata = rdata | mask_s1;
		end else begin
			we    = busy_s1 && emit_s1.is_data;
			waddr = emit_s1.addr;
			wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= req.func;
			pix_ok_s1 <= pix_ok;
			mask_s1   <= 8'(req.pixel) << req.row[2:0];
			addr_s1   <= pix_addr;
			emit_s1   <= emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_s1 && (func_s1 == FUNC_EMIT)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1 && (func_s1 == FUNC_EMIT)) begin
			out_byte_q <= emit_s1.is_data ? rdata : emit_s1.cmd;
			is_data_q  <= emit_s1.is_data;
			last_q     <= emit_s1.last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.is_data  = is_data_q;
	assign rsp.last     = last_q;

`include "oled_page_frame_packer_macros.svh"

	`OPFP_ASSERT_NEXT(a_accept_enters_s1, accept, busy_s1, "accepted beat did not reach stage one")
	`OPFP_ASSERT_IMPL(a_s1_blocks_req, busy_s1, !req.ready, "request taken during write back")
	`OPFP_ASSERT_IMPL(a_clear_quiet, clr_busy_q, !busy_s1 && !out_valid_q, "activity in clearing")
	`OPFP_ASSERT_NEXT(a_emit_gives_result, busy_s1 && (func_s1 == FUNC_EMIT), out_valid_q, "emit lost")
	`OPFP_ASSERT_IMPL(a_last_is_data, out_valid_q && last_q, is_data_q, "last on a command byte")

endmodule

FILE: verif/tb_oled_page_frame_packer.sv
// Self-checking testbench for the OLED page frame packer: predicted refresh bytes against the block.
module tb_oled_page_frame_packer;
	timeunit 1ns;
	timeprecision 1ps;

	import oled_pfp_pkg::*;

	// The watchdog gives up after this many cycles without a beat on either channel. The
	// clearing pass after reset and the long receiver hold-off both fit well inside it, as
	// do the longest gaps that random idling is likely to produce.
	localparam int unsigned STALL_LIMIT      = 4000;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned PRESSURE_BEATS   = 40;
	localparam int unsigned PHASE_BEATS      = 265;
	localparam int unsigned SETTLE_CYCLES    = 8;

	// One byte of the panel refresh stream as the block should present it.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} refresh_byte_t;

	// Scoreboard: keeps its own copy of the frame store and of the refresh cursors, works out
	// the byte that each accepted emit beat must produce, and compares the bytes that come out
	// against the oldest one still outstanding.
	class refresh_predictor;
		bit [7:0]           frame [DEPTH];
		logic [PAGE_W-1:0]  cursor_page = '0;
		logic [BYTE_W-1:0]  cursor_pos  = '0;
		refresh_byte_t      bytes_due[$];
		int unsigned        failures    = 0;

		function void take_request(input logic func, input logic [ROW_W-1:0] row,
				input logic [COL_W-1:0] col, input logic pixel);
			refresh_byte_t due;
			int unsigned   slot;
			if (func == FUNC_PIXEL) begin
				// Pixels outside the image or beyond the last column are dropped. A pixel of
				// zero ORs nothing in, so bits are only ever set here.
				if (row < IMAGE_ROWS && col < COLUMNS && (row >> 3) < PAGES) begin
					slot = int'(row >> 3) * COLUMNS + int'(col);
					frame[slot] = frame[slot] | (8'(pixel) << row[2:0]);
				end
				return;
			end
			due = '0;
			case (cursor_pos)
				POS_PAGE_CMD: begin
					due.out_byte = CMD_PAGE_BASE + 8'(cursor_page);
				end
				POS_COL_LOW: begin
					due.out_byte = CMD_COL_LOW;
				end
				POS_COL_HIGH: begin
					due.out_byte = CMD_COL_HIGH;
				end
				default: begin
					// Data bytes are read and cleared in the same step.
					slot = int'(cursor_page) * COLUMNS + int'(cursor_pos) - HEADER_LEN;
					due.out_byte = frame[slot];
					due.is_data = 1'b1;
					frame[slot] = '0;
				end
			endcase
			if (cursor_pos == POS_LAST) begin
				cursor_pos = '0;
				if (cursor_page == PAGE_LAST) begin
					cursor_page = '0;
					due.last = due.is_data;
				end else begin
					cursor_page = cursor_page + 1'b1;
				end
			end else begin
				cursor_pos = cursor_pos + 1'b1;
			end
			bytes_due.push_back(due);
		endfunction

		function void check_byte(input logic [7:0] out_byte, input logic is_data,
				input logic last);
			refresh_byte_t due;
			if (bytes_due.size() == 0) begin
				$display("%0t: byte with nothing outstanding: expected none, actual %02h/%b/%b",
					$time, out_byte, is_data, last);
				failures++;
				return;
			end
			due = bytes_due.pop_front();
			if (out_byte !== due.out_byte) begin
				$display("%0t: out_byte mismatch: expected %02h, actual %02h",
					$time, due.out_byte, out_byte);
				failures++;
			end
			if (is_data !== due.is_data) begin
				$display("%0t: is_data mismatch: expected %b, actual %b",
					$time, due.is_data, is_data);
				failures++;
			end
			if (last !== due.last) begin
				$display("%0t: last mismatch: expected %b, actual %b", $time, due.last, last);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	oled_pfp_req_if req ();
	oled_pfp_rsp_if rsp ();

	oled_page_frame_packer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	refresh_predictor model = new();

	// Idling controls. The sender's percentage is only read by the main process; the
	// receiver's is written with a nonblocking assignment so that the receiver process picks
	// up a change cleanly at the following edge.
	int unsigned src_idle_pct  = 0;
	int unsigned rsp_stall_pct = 0;
	logic        long_hold     = 1'b0;
	int unsigned hold_count    = 0;
	int unsigned quiet_cycles  = 0;

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver. Once the main process raises long_hold, ready is held low for a long stretch,
	// counted here, so that the output register fills and the block has to refuse further
	// emit beats. Otherwise ready follows the stall percentage of the current phase.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && hold_count < LONG_HOLD_CYCLES) begin
				rsp.ready <= 1'b0;
				hold_count++;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Every result beat is checked at the edge where it is taken. Values are read in the
	// active region, so they are those that stood before the edge.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			model.check_byte(rsp.out_byte, rsp.is_data, rsp.last);
		end
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offers one request beat, after any random idle cycles, and returns at the edge where it
	// is taken. Valid is left high so that a following beat can go out back to back; each
	// path through the task assigns valid at most once per edge.
	task automatic send_beat(input logic func, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic pixel);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func  <= func;
		req.row   <= row;
		req.col   <= col;
		req.pixel <= pixel;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		model.take_request(func, row, col, pixel);
	endtask

	// An emit beat carries a random pixel payload, which the block must ignore.
	task automatic send_emit();
		send_beat(FUNC_EMIT, ROW_W'($urandom), COL_W'($urandom), 1'(($urandom)));
	endtask

	// Drops valid and waits until every predicted refresh byte has come out.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (model.bytes_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Random traffic shaped like real use: a burst of pixel writes, then a run of refresh
	// bytes. One pixel in ten is unconstrained, reaching the rows and columns that are dropped;
	// half of the others land on the page being refreshed so that data bytes carry something.
	task automatic run_scenes(input int unsigned beats);
		int unsigned          done_beats;
		int unsigned          burst;
		int unsigned          pg;
		logic [ROW_W-1:0]     r;
		logic [COL_W-1:0]     c;
		done_beats = 0;
		while (done_beats < beats) begin
			burst = $urandom_range(0, 24);
			done_beats += burst;
			repeat (burst) begin
				if ($urandom_range(9) == 0) begin
					r = ROW_W'($urandom);
					c = COL_W'($urandom);
				end else begin
					pg = ($urandom_range(1) == 0) ? int'(model.cursor_page)
						: $urandom_range(PAGES - 1);
					r = ROW_W'(pg * 8 + $urandom_range(7));
					c = COL_W'($urandom_range(COLUMNS - 1));
				end
				send_beat(FUNC_PIXEL, r, c, $urandom_range(3) != 0);
			end
			burst = $urandom_range(1, 160);
			done_beats += burst;
			repeat (burst) begin
				send_emit();
			end
		end
	endtask

	initial begin
		int unsigned idle_by_phase [4];
		int unsigned stall_by_phase [4];
		idle_by_phase  = '{0, 81, 0, 25};
		stall_by_phase = '{0, 0, 81, 25};

		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.func  <= FUNC_PIXEL;
		req.row   <= '0;
		req.col   <= '0;
		req.pixel <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening. The first beat simply waits out the clearing pass. Corners of the
		// image, the rows past the image, columns past the width and a pixel of zero come first,
		// then the three commands of page 0 and its first data bytes, then a pixel into a byte
		// that has just been sent and cleared.
		send_beat(FUNC_PIXEL, 6'd0, 7'd0, 1'b1);
		send_beat(FUNC_PIXEL, 6'd59, 7'd79, 1'b1);
		send_beat(FUNC_PIXEL, 6'd7, 7'd79, 1'b1);
		send_beat(FUNC_PIXEL, 6'd8, 7'd0, 1'b1);
		send_beat(FUNC_PIXEL, 6'd60, 7'd5, 1'b1);
		send_beat(FUNC_PIXEL, 6'd63, 7'd127, 1'b1);
		send_beat(FUNC_PIXEL, 6'd0, 7'd80, 1'b1);
		send_beat(FUNC_PIXEL, 6'd5, 7'd0, 1'b0);
		send_beat(FUNC_PIXEL, 6'd42, 7'd42, 1'b1);
		send_beat(FUNC_PIXEL, 6'd21, 7'd85, 1'b1);
		send_beat(FUNC_PIXEL, 6'd3, 7'd2, 1'b1);
		send_beat(FUNC_PIXEL, 6'd7, 7'd1, 1'b1);
		send_beat(FUNC_EMIT, 6'd63, 7'd127, 1'b1);
		send_beat(FUNC_EMIT, 6'd0, 7'd0, 1'b0);
		send_beat(FUNC_EMIT, 6'd21, 7'd42, 1'b1);
		repeat (4) begin
			send_emit();
		end
		send_beat(FUNC_PIXEL, 6'd1, 7'd0, 1'b1);
		send_beat(FUNC_PIXEL, 6'd6, 7'd2, 1'b1);
		drain();

		// Back-pressure: the receiver holds off while emit beats keep coming, so the result
		// register fills and the request side must stall until the hold ends.
		long_hold <= 1'b1;
		repeat (PRESSURE_BEATS) begin
			send_emit();
		end
		drain();

		// Random phases: no idling, sender idle, receiver stalling, then both.
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = idle_by_phase[p];
			rsp_stall_pct <= stall_by_phase[p];
			run_scenes(PHASE_BEATS);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (model.failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
